[design/mtfo_pkg.sv]
`timescale 1ns / 1ps

package mtfo_pkg;

	localparam int WORD_W    = 32;
	localparam int MID_INDEX = 397;
	localparam int IDX_W     = $clog2(MID_INDEX + 1);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0]  idx_t;

	localparam word_t INIT_MULT    = 32'd1812433253;
	localparam word_t UPPER_MASK   = 32'h8000_0000;
	localparam word_t LOWER_MASK   = 32'h7fff_ffff;
	localparam word_t TWIST_MATRIX = 32'h9908_b0df;
	localparam word_t TEMPER_B     = 32'd2636928640;
	localparam word_t TEMPER_C     = 32'd4022730752;

endpackage

[design/mt19937_first_output_top.sv]
`timescale 1ns / 1ps

// Pipeline: 398 register stages (397 seeding + twist/temper).
// Throughput: one seed per cycle while the pipe is not held; one 32x32 constant multiply per seeding stage.
// The whole pipe advances together; it holds while the output register is full and not taken.
// Reset (arst_n low, async) clears all valid bits; data registers are not reset.
module mt19937_first_output_top
	import mtfo_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  word_t seed_value,
	output logic  out_valid,
	input  logic  out_ready,
	output word_t first_random
);

	logic  adv;
	logic  v [0:MID_INDEX];
	word_t w [0:MID_INDEX];
	word_t y [0:MID_INDEX];

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	assign v[0] = in_valid;
	assign w[0] = seed_value;
	assign y[0] = seed_value;

	genvar k;
	generate
		for (k = 1; k <= MID_INDEX; k++) begin : g_init
			word_t y_in;
			if (k == 2) begin : g_mix
				// y = top bit of word 0, low 31 bits of word 1
				assign y_in = (y[1] & UPPER_MASK) | (w[1] & LOWER_MASK);
			end else begin : g_pass
				assign y_in = y[k-1];
			end

			mtfo_init_stage u_stage (
				.clk       (clk),
				.arst_n    (arst_n),
				.adv       (adv),
				.idx       (idx_t'(k)),
				.valid_in  (v[k-1]),
				.word_in   (w[k-1]),
				.twist_in  (y_in),
				.valid_out (v[k]),
				.word_out  (w[k]),
				.twist_out (y[k])
			);
		end
	endgenerate

	mtfo_twist_temper u_final (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.valid_in  (v[MID_INDEX]),
		.mid_word  (w[MID_INDEX]),
		.twist_y   (y[MID_INDEX]),
		.valid_out (out_valid),
		.result    (first_random)
	);

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v[1])
		else $error("accepted request did not enter first stage");

	a_out_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v[MID_INDEX]))
		else $error("result appeared without a valid last seeding stage");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v[1]) && $stable(v[MID_INDEX]) && $stable(w[MID_INDEX]))
		else $error("pipeline moved during stall");

	a_drain_moves: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v[MID_INDEX] |=> out_valid)
		else $error("last stage item lost on advance");

endmodule

[design/mtfo_init_stage.sv]
`timescale 1ns / 1ps

// One step of the seeding recurrence: w_k = MULT * (w ^ (w >> 30)) + k.
module mtfo_init_stage
	import mtfo_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  idx_t  idx,
	input  logic  valid_in,
	input  word_t word_in,
	input  word_t twist_in,
	output logic  valid_out,
	output word_t word_out,
	output word_t twist_out
);

	word_t mixed;
	word_t prod;
	word_t word_s1;
	word_t twist_s1;
	logic  valid_s1;

	assign mixed = word_in ^ (word_in >> 30);
	assign prod  = word_t'(mixed * INIT_MULT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_s1  <= prod + word_t'(idx);
			twist_s1 <= twist_in;
		end
	end

	assign valid_out = valid_s1;
	assign word_out  = word_s1;
	assign twist_out = twist_s1;

endmodule

[design/mtfo_twist_temper.sv]
`timescale 1ns / 1ps

// Twist of words 0 and 1 against word 397, then tempering; result lands in the output register.
module mtfo_twist_temper
	import mtfo_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  valid_in,
	input  word_t mid_word,
	input  word_t twist_y,
	output logic  valid_out,
	output word_t result
);

	word_t x0;
	word_t x1;
	word_t x2;
	word_t x3;
	word_t x4;
	word_t result_q;
	logic  valid_q;

	always_comb begin
		x0 = mid_word ^ (twist_y >> 1);
		if (twist_y[0]) begin
			x0 = x0 ^ TWIST_MATRIX;
		end
		x1 = x0 ^ (x0 >> 11);
		x2 = x1 ^ ((x1 << 7) & TEMPER_B);
		x3 = x2 ^ ((x2 << 15) & TEMPER_C);
		x4 = x3 ^ (x3 >> 18);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= x4;
		end
	end

	assign valid_out = valid_q;
	assign result    = result_q;

endmodule

[tb/mt19937_first_output_top_tb.sv]
`timescale 1ns / 1ps

module mt19937_first_output_top_tb;
	import mtfo_pkg::*;

	localparam int PIPE_LATENCY = 398;
	localparam int DRAIN_LIMIT  = 20000;

	typedef struct {
		word_t seed;
		word_t result;
	} seed_result_t;

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	word_t seed_value;
	logic  out_valid;
	logic  out_ready;
	word_t first_random;

	seed_result_t pending_results[$];
	int           mismatch_count;
	bit           in_idle_en;
	bit           out_idle_en;

	mt19937_first_output_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.seed_value   (seed_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.first_random (first_random)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// one step of the seeding recurrence, wraps mod 2^32
	function automatic word_t seed_step(input word_t prev, input word_t idx);
		word_t prod;
		prod = INIT_MULT * (prev ^ (prev >> 30));
		return prod + idx;
	endfunction

	function automatic word_t first_output_of(input word_t seed);
		word_t w0;
		word_t w1;
		word_t cur;
		word_t y;
		word_t x;
		w0  = seed;
		w1  = seed_step(w0, word_t'(1));
		cur = w1;
		for (int k = 2; k <= MID_INDEX; k++)
			cur = seed_step(cur, word_t'(k));
		y = (w0 & UPPER_MASK) | (w1 & LOWER_MASK);
		x = cur ^ (y >> 1);
		if (y[0])
			x = x ^ TWIST_MATRIX;
		x = x ^ (x >> 11);
		x = x ^ ((x << 7) & TEMPER_B);
		x = x ^ ((x << 15) & TEMPER_C);
		x = x ^ (x >> 18);
		return x;
	endfunction

	// receiver side: random backpressure when out_idle_en is set, else always ready; changes on the falling edge
	always @(negedge clk) begin
		if (arst_n)
			out_ready = out_idle_en ? ($urandom_range(0, 99) >= 8) : 1'b1;
	end

	always @(posedge clk) begin
		seed_result_t exp_item;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %h", $time,
					first_random);
				mismatch_count++;
			end else begin
				exp_item = pending_results.pop_front();
				if (first_random !== exp_item.result) begin
					$display("%0t: first_random mismatch, seed %h: expected %h, actual %h",
						$time, exp_item.seed, exp_item.result, first_random);
					mismatch_count++;
				end
			end
		end
	end

	task automatic send_seed(input word_t seed);
		seed_result_t item;
		@(negedge clk);
		while (in_idle_en && $urandom_range(0, 99) < 8) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid   = 1'b1;
		seed_value = seed;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		item.seed   = seed;
		item.result = first_output_of(seed);
		pending_results = {pending_results, item};
	endtask

	task automatic release_request();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic test_directed_seeds();
		word_t seeds[$];
		seeds = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000,
			32'h7fff_ffff, 32'd5489, 32'haaaa_aaaa, 32'h5555_5555, 32'h0000_0002,
			32'h4000_0000, 32'hffff_fffe, 32'h0001_0000, 32'h0000_8000,
			32'hdead_beef, 32'h1234_5678, 32'h0000_ffff, 32'hffff_0000};
		in_idle_en  = 1'b0;
		out_idle_en = 1'b0;
		foreach (seeds[i])
			send_seed(seeds[i]);
		release_request();
	endtask

	task automatic test_random_seeds_with_gaps();
		in_idle_en  = 1'b1;
		out_idle_en = 1'b1;
		for (int n = 0; n < 425; n++)
			send_seed($urandom());
		release_request();
	endtask

	// long burst with no gaps on either side
	task automatic test_back_to_back_seeds();
		in_idle_en  = 1'b0;
		out_idle_en = 1'b0;
		for (int n = 0; n < 180; n++)
			send_seed($urandom());
		release_request();
	endtask

	task automatic drain_and_report();
		int waited;
		waited = 0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (PIPE_LATENCY + 20)
			@(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived: expected %h, actual none", $time,
				pending_results.size(), pending_results[0].result);
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		seed_value     = '0;
		out_ready      = 1'b0;
		in_idle_en     = 1'b0;
		out_idle_en    = 1'b0;
		mismatch_count = 0;
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_seeds();
		test_random_seeds_with_gaps();
		test_back_to_back_seeds();
		test_random_seeds_with_gaps();
		drain_and_report();
	end

	initial begin
		#5ms;
		$display("FAILURE");
		$finish;
	end

endmodule

[files.f]
design/mtfo_pkg.sv
design/mtfo_init_stage.sv
design/mtfo_twist_temper.sv
design/mt19937_first_output_top.sv
tb/mt19937_first_output_top_tb.sv
